FILE: design/utf8d_pkg.sv
// Shared widths and byte-class constants for the UTF-8 stream decoder.
package utf8d_pkg;

  localparam int BYTE_W   = 8;
  localparam int CP_W     = 21;
  localparam int CP_BYTES = (CP_W + 7) / 8;
  localparam int TDATA_W  = CP_BYTES * 8;
  localparam int REM_W    = 2;

  typedef logic [REM_W-1:0] rem_t;
  typedef logic [CP_W-1:0]  cp_t;

  localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
  localparam logic [BYTE_W-1:0] PAT_LEAD4  = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
  localparam logic [BYTE_W-1:0] PAT_LEAD3  = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
  localparam logic [BYTE_W-1:0] PAT_LEAD2  = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
  localparam logic [BYTE_W-1:0] PAT_CONT   = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_ASCII = 8'h80;
  localparam logic [BYTE_W-1:0] PAT_ASCII  = 8'h00;

  localparam logic ACTION_SKIP   = 1'b0;
  localparam logic ACTION_REPORT = 1'b1;

endpackage

FILE: design/utf8_stream_decoder_top.sv
// Byte-serial UTF-8 decoder with stream ports and an error-action register.
//
//  channel   dir   payload
//  s_axis    in    tdata[7:0] = data_byte
//  m_axis    out   tdata[20:0] = code_point (upper bits zero), tuser = is_error
//  cfg       in    cfg_data = error_action
//
// One byte is taken per cycle unless the input stalls; its result, if any,
// appears in the output register on the next cycle. The decode is a single
// pass of logic from the sequence state to the output register. Reset sets
// error_action to report and clears the sequence state. The input stalls only
// while an unread result sits in the output register.
module utf8_stream_decoder_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [utf8d_pkg::BYTE_W-1:0]  s_axis_tdata,   // data_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [utf8d_pkg::TDATA_W-1:0] m_axis_tdata,   // code_point, zero fill
  output logic                          m_axis_tuser,   // is_error
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data        // error_action
);
  import utf8d_pkg::*;

  logic       error_action;
  rem_t       remaining;
  rem_t       remaining_next;
  cp_t        acc;
  cp_t        acc_next;
  cp_t        out_cp;
  cp_t        out_cp_next;
  logic       out_err;
  logic       out_err_next;
  logic       emit;
  logic       lead_ok;
  rem_t       lead_rem;
  cp_t        lead_acc;
  logic       is_cont;
  logic       accept;
  logic [BYTE_W-1:0] b;

  assign b             = s_axis_tdata;
  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {{(TDATA_W - CP_W){1'b0}}, out_cp};
  assign m_axis_tuser  = out_err;
  assign is_cont       = (b & MASK_CONT) == PAT_CONT;

  always_comb begin
    lead_ok  = 1'b1;
    lead_rem = rem_t'(0);
    lead_acc = '0;
    if ((b & MASK_LEAD4) == PAT_LEAD4) begin
      lead_rem = rem_t'(3);
      lead_acc = cp_t'(b[2:0]);
    end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
      lead_rem = rem_t'(2);
      lead_acc = cp_t'(b[3:0]);
    end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
      lead_rem = rem_t'(1);
      lead_acc = cp_t'(b[4:0]);
    end else if ((b & MASK_ASCII) == PAT_ASCII) begin
      lead_acc = cp_t'(b);
    end else begin
      lead_ok = 1'b0;
    end
  end

  always_comb begin
    remaining_next = remaining;
    acc_next       = acc;
    emit           = 1'b0;
    out_err_next   = 1'b0;
    out_cp_next    = '0;
    if (remaining != rem_t'(0)) begin
      if (is_cont) begin
        remaining_next = remaining - rem_t'(1);
        acc_next       = {acc[CP_W-7:0], b[5:0]};
        emit           = remaining_next == rem_t'(0);
        out_cp_next    = acc_next;
      end else if (error_action == ACTION_REPORT) begin
        emit         = 1'b1;
        out_err_next = 1'b1;
      end else if (lead_ok) begin
        // Resynchronize: the broken sequence is dropped and this byte restarts.
        remaining_next = lead_rem;
        acc_next       = lead_acc;
        emit           = lead_rem == rem_t'(0);
        out_cp_next    = lead_acc;
      end else begin
        remaining_next = rem_t'(0);
        acc_next       = '0;
      end
    end else if (lead_ok) begin
      remaining_next = lead_rem;
      acc_next       = lead_acc;
      emit           = lead_rem == rem_t'(0);
      out_cp_next    = lead_acc;
    end else if (error_action == ACTION_REPORT) begin
      emit         = 1'b1;
      out_err_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_action  <= ACTION_REPORT;
      remaining     <= rem_t'(0);
      acc           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        error_action <= cfg_data;
      end
      if (accept) begin
        remaining     <= remaining_next;
        acc           <= acc_next;
        m_axis_tvalid <= emit;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_cp  <= out_cp_next;
      out_err <= out_err_next;
    end
  end

endmodule

FILE: tb/utf8_stream_decoder_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 stream decoder with a code point scoreboard.
module utf8_stream_decoder_top_tb;
  import utf8d_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct {
    cp_t  cp;
    logic err;
  } cp_result_t;

  // Tracks the decoder's sequence state and holds the code points still to come out.
  class code_point_board;
    logic       action;
    rem_t       seq_left;
    cp_t        seq_acc;
    cp_result_t pending[$];
    int         errors;

    function new();
      action   = ACTION_REPORT;
      seq_left = '0;
      seq_acc  = '0;
      errors   = 0;
    endfunction

    task complain(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void push(input cp_t cp, input logic err);
      cp_result_t r;
      r.cp  = cp;
      r.err = err;
      pending.push_back(r);
    endfunction

    function bit load_lead(input logic [BYTE_W-1:0] b);
      if ((b & MASK_LEAD4) == PAT_LEAD4) begin
        seq_left = 2'd3;
        seq_acc  = cp_t'(b[2:0]);
      end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
        seq_left = 2'd2;
        seq_acc  = cp_t'(b[3:0]);
      end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
        seq_left = 2'd1;
        seq_acc  = cp_t'(b[4:0]);
      end else if ((b & MASK_ASCII) == PAT_ASCII) begin
        seq_left = 2'd0;
        seq_acc  = cp_t'(b);
      end else begin
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void take_byte(input logic [BYTE_W-1:0] b);
      if (seq_left != 0) begin
        if ((b & MASK_CONT) == PAT_CONT) begin
          seq_left = seq_left - 2'd1;
          seq_acc  = {seq_acc[CP_W-7:0], b[5:0]};
        end else if (action == ACTION_REPORT) begin
          // The pending sequence survives a reported bad continuation.
          push('0, 1'b1);
          return;
        end else begin
          // In skip mode the offending byte is retried as a lead byte.
          seq_left = '0;
          seq_acc  = '0;
          if (!load_lead(b)) return;
        end
      end else if (!load_lead(b)) begin
        if (action == ACTION_REPORT) push('0, 1'b1);
        return;
      end
      if (seq_left == 0) push(seq_acc, 1'b0);
    endfunction

    task match_result(input logic [TDATA_W-1:0] data, input logic err);
      cp_result_t want;
      if (pending.size() == 0) begin
        complain($sformatf("unexpected result code_point=%h is_error=%b", data, err));
        return;
      end
      want = pending.pop_front();
      if (data != TDATA_W'(want.cp))
        complain($sformatf("code_point %h, expected %h", data, want.cp));
      if (err != want.err)
        complain($sformatf("is_error %b, expected %b", err, want.err));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [BYTE_W-1:0]    s_axis_tdata = '0;   // data_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;        // code_point, zero fill
  logic                 m_axis_tuser;        // is_error
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_data = 1'b0;     // error_action

  logic                 calm = 1'b0;
  int                   stall_cycles = 0;
  code_point_board      board;
  logic [BYTE_W-1:0]    byte_list[$];

  utf8_stream_decoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 38);
  end

  // Results are checked before the byte of the same edge is noted, since that
  // byte's result can only appear later.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) board.match_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) board.take_byte(s_axis_tdata);
      if (cfg_valid && cfg_ready) board.action = cfg_data;
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!calm && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 38);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_list();
    foreach (byte_list[i]) send_byte(byte_list[i]);
  endtask

  // The first edge lets the monitor note the last accepted byte before the
  // scoreboard is polled. A dropped byte leaves nothing to wait for, so a few
  // spare cycles follow the drain.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_action(input logic value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed sequences with random payload, some cut short, some raw noise.
  task automatic run_phase(input int unsigned target);
    int unsigned       sent;
    int unsigned       roll;
    int unsigned       len;
    int unsigned       keep;
    logic [BYTE_W-1:0] lead;
    sent = 0;
    while (sent < target) begin
      roll = $urandom_range(99);
      if (roll >= 88) begin
        send_byte(BYTE_W'($urandom_range(255)));
      end else begin
        len  = $urandom_range(1, 4);
        keep = (roll < 74) ? len : $urandom_range(1, len);
        case (len)
          1: begin
            lead = {1'b0, 7'($urandom)};
          end
          2: begin
            lead = {3'b110, 5'($urandom)};
          end
          3: begin
            lead = {4'b1110, 4'($urandom)};
          end
          default: begin
            lead = {5'b11110, 3'($urandom)};
          end
        endcase
        send_byte(lead);
        for (int i = 1; i < keep; i++) send_byte({2'b10, 6'($urandom)});
        sent += keep;
      end
    end
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_action(ACTION_REPORT);
    // ASCII extremes, full sequences up to the 21-bit maximum, bad leads, and a
    // bad continuation that leaves the open sequence waiting.
    byte_list = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                  8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h80, 8'hFF, 8'hC3, 8'h41, 8'hA9};
    send_list();

    write_action(ACTION_SKIP);
    // Dropped lead, then bad continuations retried as ASCII, a new lead, and a bad lead.
    byte_list = '{8'hFF, 8'hC3, 8'h41, 8'hE2, 8'hC3, 8'hA9, 8'hF0, 8'h80, 8'hFE, 8'h80};
    send_list();

    run_phase(210);
    write_action(ACTION_REPORT);
    run_phase(210);
    settle();
    calm <= 1'b1;
    run_phase(210);
    settle();
    calm <= 1'b0;
    write_action(ACTION_SKIP);
    run_phase(210);
    write_action(ACTION_REPORT);
    run_phase(210);
    write_action(ACTION_SKIP);
    run_phase(210);

    settle();
    repeat (8) @(posedge clk);
    if (board.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
